[hw/rtl/pffl_pkg.sv]
package pffl_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = IDX_W + 1;
    localparam int FRAME_W    = 20;
    localparam int PAGES_W    = 11;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC_ONE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC_RUN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_RUN  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_RUN  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_NODE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP,
        ST_RUN_LOAD,
        ST_RUN_CHECK,
        ST_RUN_STEP,
        ST_RUN_UNLINK,
        ST_REL_RD,
        ST_REL_WR,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0]   rd_addr;
        logic               frame_we;
        logic [IDX_W-1:0]   frame_waddr;
        logic [FRAME_W-1:0] frame_wdata;
        logic               next_we;
        logic [IDX_W-1:0]   next_waddr;
        logic [IDX_W-1:0]   next_wdata;
    } node_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
    } spare_req_t;

endpackage

[hw/rtl/pffl_ram.sv]
module pffl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/pffl_ctrl.sv]
module pffl_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic [pffl_pkg::CMD_W-1:0]         command,
    input  logic [pffl_pkg::PAGES_W-1:0]       page_count,
    input  logic [pffl_pkg::FRAME_W-1:0]       page_frame,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [pffl_pkg::STATUS_W-1:0]      status,
    output logic [pffl_pkg::FRAME_W-1:0]       first_frame,
    output logic [pffl_pkg::PAGES_W-1:0]       granted_pages,
    output pffl_pkg::node_req_t                node_req,
    output pffl_pkg::spare_req_t               spare_req,
    input  logic [pffl_pkg::FRAME_W-1:0]       frame_rd,
    input  logic [pffl_pkg::IDX_W-1:0]         next_rd,
    input  logic [pffl_pkg::IDX_W-1:0]         spare_rd
);

    localparam int IDX_W   = pffl_pkg::IDX_W;
    localparam int CNT_W   = pffl_pkg::CNT_W;
    localparam int FRAME_W = pffl_pkg::FRAME_W;
    localparam int PAGES_W = pffl_pkg::PAGES_W;
    localparam logic [CNT_W-1:0] NODES = CNT_W'(pffl_pkg::NODE_COUNT);

    pffl_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]   head_reg, tail_reg;
    logic [CNT_W-1:0]   length_reg, spare_top_reg, never_used_reg;
    logic [PAGES_W-1:0] cnt_reg, idx_reg, found_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   last_reg, last_next_reg, prev_reg, run_head_reg, walk_reg;
    logic [FRAME_W-1:0] last_frame_reg, run_frame_reg, frame_reg;
    logic               prev_valid_reg;
    logic [pffl_pkg::STATUS_W-1:0] rs_status_reg;
    logic [FRAME_W-1:0]            rs_frame_reg;
    logic [PAGES_W-1:0]            rs_pages_reg;
    logic               out_valid_reg;
    logic [pffl_pkg::STATUS_W-1:0] out_status_reg;
    logic [FRAME_W-1:0]            out_frame_reg;
    logic [PAGES_W-1:0]            out_pages_reg;

    logic               accept;
    logic               run_bad;
    logic [CNT_W:0]     avail;
    logic [IDX_W-1:0]   take_node;
    logic               adjacent;
    logic               last_step;
    logic               out_load;

    assign accept    = cmd_valid && (state_reg == pffl_pkg::ST_IDLE);
    assign run_bad   = (length_reg == '0) || (page_count == '0)
                       || (CNT_W'(page_count) > length_reg);
    assign avail     = {1'b0, spare_top_reg}
                       + ((never_used_reg < NODES) ? ({1'b0, NODES} - {1'b0, never_used_reg})
                                                   : '0);
    assign take_node = (spare_top_reg != '0) ? spare_rd : never_used_reg[IDX_W-1:0];
    assign adjacent  = ({1'b0, last_frame_reg} + (FRAME_W+1)'(1)) == {1'b0, frame_rd};
    assign last_step = (idx_reg + PAGES_W'(1)) == cnt_reg;
    assign out_load  = (state_reg == pffl_pkg::ST_DONE) && (!out_valid_reg || !res_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pffl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        pffl_pkg::CMD_ALLOC_ONE:
                            state_next = (length_reg == '0) ? pffl_pkg::ST_DONE
                                                            : pffl_pkg::ST_POP;
                        pffl_pkg::CMD_ALLOC_RUN:
                            state_next = run_bad ? pffl_pkg::ST_DONE : pffl_pkg::ST_RUN_LOAD;
                        pffl_pkg::CMD_FREE_RUN:
                            state_next = ((CNT_W+1)'(page_count) > avail || page_count == '0)
                                         ? pffl_pkg::ST_DONE : pffl_pkg::ST_FREE_RD;
                        default:
                            state_next = pffl_pkg::ST_DONE;
                    endcase
                end
            end
            pffl_pkg::ST_POP:      state_next = pffl_pkg::ST_DONE;
            pffl_pkg::ST_RUN_LOAD: state_next = pffl_pkg::ST_RUN_CHECK;
            pffl_pkg::ST_RUN_CHECK:
            begin
                if (found_reg >= cnt_reg)
                begin
                    state_next = pffl_pkg::ST_RUN_UNLINK;
                end
                else if (pos_reg >= length_reg)
                begin
                    state_next = pffl_pkg::ST_DONE;
                end
                else
                begin
                    state_next = pffl_pkg::ST_RUN_STEP;
                end
            end
            pffl_pkg::ST_RUN_STEP:   state_next = pffl_pkg::ST_RUN_CHECK;
            pffl_pkg::ST_RUN_UNLINK: state_next = pffl_pkg::ST_REL_RD;
            pffl_pkg::ST_REL_RD:     state_next = pffl_pkg::ST_REL_WR;
            pffl_pkg::ST_REL_WR:
                state_next = last_step ? pffl_pkg::ST_DONE : pffl_pkg::ST_REL_RD;
            pffl_pkg::ST_FREE_RD:    state_next = pffl_pkg::ST_FREE_WR;
            pffl_pkg::ST_FREE_WR:
                state_next = last_step ? pffl_pkg::ST_DONE : pffl_pkg::ST_FREE_RD;
            pffl_pkg::ST_DONE:
                state_next = out_load ? pffl_pkg::ST_IDLE : pffl_pkg::ST_DONE;
            default:                 state_next = pffl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_stall             = (state_reg != pffl_pkg::ST_IDLE);
        node_req              = '0;
        spare_req             = '0;
        node_req.rd_addr      = head_reg;
        spare_req.rd_addr     = IDX_W'(spare_top_reg - CNT_W'(1));
        case (state_reg)
            pffl_pkg::ST_RUN_CHECK: node_req.rd_addr = last_next_reg;
            pffl_pkg::ST_REL_RD:    node_req.rd_addr = walk_reg;
            pffl_pkg::ST_POP:
            begin
                spare_req.we    = (spare_top_reg != NODES);
                spare_req.waddr = spare_top_reg[IDX_W-1:0];
                spare_req.wdata = head_reg;
            end
            pffl_pkg::ST_REL_WR:
            begin
                spare_req.we    = (spare_top_reg != NODES);
                spare_req.waddr = spare_top_reg[IDX_W-1:0];
                spare_req.wdata = walk_reg;
            end
            pffl_pkg::ST_RUN_UNLINK:
            begin
                node_req.next_we    = prev_valid_reg;
                node_req.next_waddr = prev_reg;
                node_req.next_wdata = last_next_reg;
            end
            pffl_pkg::ST_FREE_WR:
            begin
                node_req.frame_we    = 1'b1;
                node_req.frame_waddr = take_node;
                node_req.frame_wdata = frame_reg;
                node_req.next_we     = (length_reg != '0);
                node_req.next_waddr  = tail_reg;
                node_req.next_wdata  = take_node;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pffl_pkg::ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            length_reg     <= '0;
            spare_top_reg  <= '0;
            never_used_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                pffl_pkg::ST_POP:
                begin
                    if (length_reg == CNT_W'(1))
                    begin
                        head_reg <= '0;
                        tail_reg <= '0;
                    end
                    else
                    begin
                        head_reg <= next_rd;
                    end
                    length_reg <= length_reg - CNT_W'(1);
                    if (spare_top_reg != NODES)
                    begin
                        spare_top_reg <= spare_top_reg + CNT_W'(1);
                    end
                end
                pffl_pkg::ST_RUN_UNLINK:
                begin
                    if (!prev_valid_reg)
                    begin
                        head_reg <= (pos_reg == length_reg) ? '0 : last_next_reg;
                    end
                    if (pos_reg == length_reg)
                    begin
                        tail_reg <= prev_valid_reg ? prev_reg : '0;
                    end
                    length_reg <= length_reg - CNT_W'(cnt_reg);
                end
                pffl_pkg::ST_REL_WR:
                begin
                    if (spare_top_reg != NODES)
                    begin
                        spare_top_reg <= spare_top_reg + CNT_W'(1);
                    end
                end
                pffl_pkg::ST_FREE_WR:
                begin
                    if (length_reg == '0)
                    begin
                        head_reg <= take_node;
                    end
                    tail_reg   <= take_node;
                    length_reg <= length_reg + CNT_W'(1);
                    if (spare_top_reg != '0)
                    begin
                        spare_top_reg <= spare_top_reg - CNT_W'(1);
                    end
                    else
                    begin
                        never_used_reg <= never_used_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= rs_status_reg;
            out_frame_reg  <= rs_frame_reg;
            out_pages_reg  <= rs_pages_reg;
        end
        case (state_reg)
            pffl_pkg::ST_IDLE:
            begin
                cnt_reg       <= page_count;
                frame_reg     <= page_frame;
                idx_reg       <= '0;
                rs_frame_reg  <= '0;
                rs_pages_reg  <= '0;
                if (command != pffl_pkg::CMD_FREE_RUN)
                begin
                    rs_status_reg <= pffl_pkg::STATUS_NO_RUN;
                end
                else if ((CNT_W+1)'(page_count) > avail)
                begin
                    rs_status_reg <= pffl_pkg::STATUS_NO_NODE;
                end
                else
                begin
                    rs_status_reg <= pffl_pkg::STATUS_OK;
                end
            end
            pffl_pkg::ST_POP:
            begin
                rs_status_reg <= pffl_pkg::STATUS_OK;
                rs_frame_reg  <= frame_rd;
                rs_pages_reg  <= PAGES_W'(1);
            end
            pffl_pkg::ST_RUN_LOAD:
            begin
                last_reg       <= head_reg;
                last_frame_reg <= frame_rd;
                last_next_reg  <= next_rd;
                run_head_reg   <= head_reg;
                run_frame_reg  <= frame_rd;
                found_reg      <= PAGES_W'(1);
                pos_reg        <= CNT_W'(1);
                prev_valid_reg <= 1'b0;
            end
            pffl_pkg::ST_RUN_STEP:
            begin
                if (adjacent)
                begin
                    found_reg <= found_reg + PAGES_W'(1);
                end
                else
                begin
                    prev_reg       <= last_reg;
                    prev_valid_reg <= 1'b1;
                    run_head_reg   <= last_next_reg;
                    run_frame_reg  <= frame_rd;
                    found_reg      <= PAGES_W'(1);
                end
                last_reg       <= last_next_reg;
                last_frame_reg <= frame_rd;
                last_next_reg  <= next_rd;
                pos_reg        <= pos_reg + CNT_W'(1);
            end
            pffl_pkg::ST_RUN_UNLINK:
            begin
                rs_status_reg <= pffl_pkg::STATUS_OK;
                rs_frame_reg  <= run_frame_reg;
                rs_pages_reg  <= cnt_reg;
                walk_reg      <= run_head_reg;
            end
            pffl_pkg::ST_REL_WR:
            begin
                walk_reg <= next_rd;
                idx_reg  <= idx_reg + PAGES_W'(1);
            end
            pffl_pkg::ST_FREE_WR:
            begin
                frame_reg <= frame_reg + FRAME_W'(1);
                idx_reg   <= idx_reg + PAGES_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign first_frame   = out_frame_reg;
    assign granted_pages = out_pages_reg;

endmodule

[hw/rtl/page_frame_free_list_allocator_unit.sv]
// Free-list page frame allocator: one command at a time, one result per command.
// A single-page allocate pops the list head; a free of N pages appends N nodes; a contiguous
// allocate walks the list for a run of N adjacent frames, then unlinks it and releases the N
// nodes to the spare stack; a command refused at acceptance goes straight to the result.
// The result is valid in the same cycle as the next command can be taken; a stalled result
// holds the next finished result, and so the block, until it is taken.
// Each step reads the node memories through a registered read port; release and free steps
// then write back. A finished result sits in an output register.
module page_frame_free_list_allocator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [pffl_pkg::CMD_W-1:0]    command,
    input  logic [pffl_pkg::PAGES_W-1:0]  page_count,
    input  logic [pffl_pkg::FRAME_W-1:0]  page_frame,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [pffl_pkg::STATUS_W-1:0] status,
    output logic [pffl_pkg::FRAME_W-1:0]  first_frame,
    output logic [pffl_pkg::PAGES_W-1:0]  granted_pages
);

    pffl_pkg::node_req_t              node_req;
    pffl_pkg::spare_req_t             spare_req;
    logic [pffl_pkg::FRAME_W-1:0]     frame_rd;
    logic [pffl_pkg::IDX_W-1:0]       next_rd;
    logic [pffl_pkg::IDX_W-1:0]       spare_rd;

    pffl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .command       (command),
        .page_count    (page_count),
        .page_frame    (page_frame),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .status        (status),
        .first_frame   (first_frame),
        .granted_pages (granted_pages),
        .node_req      (node_req),
        .spare_req     (spare_req),
        .frame_rd      (frame_rd),
        .next_rd       (next_rd),
        .spare_rd      (spare_rd)
    );

    pffl_ram #(
        .WIDTH (pffl_pkg::FRAME_W),
        .DEPTH (pffl_pkg::NODE_COUNT)
    ) u_frame_ram (
        .clk   (clk),
        .we    (node_req.frame_we),
        .waddr (node_req.frame_waddr),
        .wdata (node_req.frame_wdata),
        .raddr (node_req.rd_addr),
        .rdata (frame_rd)
    );

    pffl_ram #(
        .WIDTH (pffl_pkg::IDX_W),
        .DEPTH (pffl_pkg::NODE_COUNT)
    ) u_next_ram (
        .clk   (clk),
        .we    (node_req.next_we),
        .waddr (node_req.next_waddr),
        .wdata (node_req.next_wdata),
        .raddr (node_req.rd_addr),
        .rdata (next_rd)
    );

    pffl_ram #(
        .WIDTH (pffl_pkg::IDX_W),
        .DEPTH (pffl_pkg::NODE_COUNT)
    ) u_spare_ram (
        .clk   (clk),
        .we    (spare_req.we),
        .waddr (spare_req.waddr),
        .wdata (spare_req.wdata),
        .raddr (spare_req.rd_addr),
        .rdata (spare_rd)
    );

endmodule

[hw/rtl/pffl_checker.sv]
module pffl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_stall,
    input logic [pffl_pkg::STATUS_W-1:0] status,
    input logic [pffl_pkg::FRAME_W-1:0]  first_frame,
    input logic [pffl_pkg::PAGES_W-1:0]  granted_pages
);

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != pffl_pkg::STATUS_OK |-> first_frame == '0 && granted_pages == '0)
        else $error("failed item carries a grant");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status == pffl_pkg::STATUS_OK || status == pffl_pkg::STATUS_NO_RUN
                      || status == pffl_pkg::STATUS_NO_NODE)
        else $error("undefined status");

    a_grant_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> granted_pages <= pffl_pkg::PAGES_W'(pffl_pkg::NODE_COUNT))
        else $error("grant exceeds pool");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(first_frame) && $stable(status))
        else $error("stalled item changed");

endmodule

bind page_frame_free_list_allocator_unit pffl_checker u_pffl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .first_frame   (first_frame),
    .granted_pages (granted_pages)
);
